// File: rtl/mas_pkg.sv
package mas_pkg;

  localparam int DEF_MAX_COUNT = 64;
  localparam int VALUE_W       = 64;
  localparam int MAG_W         = 63;
  localparam int POS_W         = 6;
  localparam int OUT_DATA_W    = 8;

  // magnitude of +inf; anything above is a nan
  localparam logic [MAG_W-1:0] INF_MAG = {11'h7ff, 52'd0};

  // one slot of the insertion chain
  typedef struct packed {
    logic             occ;
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] pos;
  } mas_entry_t;

  // per-cycle command from the sequencer to the cell row
  typedef struct packed {
    logic insert;
    logic drain;
  } mas_cmd_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } mas_state_t;

endpackage

// File: rtl/magnitude_argsort_top.sv
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | s_tdata = value_bits, s_tlast = last_value
// m       | out | m_tvalid/m_tready | m_tdata = rank_index, m_tlast = last_rank
//
// one input word per cycle while loading; each non-nan word is placed in the sorted
// cell row while the row has room (one magnitude compare per cell, all in parallel)
// after the last word the row shifts toward the head, one index per cycle while
// m_tready is high, and loading resumes once the head cell is empty
// rst clears the occupied bits and the word counter; cell payload is not reset
// m_tready low holds the row; s_tready is low for the whole drain
module magnitude_argsort_top
  import mas_pkg::*;
#(
  parameter int MAX_COUNT = DEF_MAX_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_W-1:0]    s_tdata,   // [63:0] value_bits
  input  logic                  s_tlast,   // last_value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [5:0] rank_index, [7:6] zero
  output logic                  m_tlast    // last_rank
);

  localparam int CNT_W = $clog2(MAX_COUNT + 1);

  mas_cmd_t         cmd;
  logic [CNT_W-1:0] count;
  mas_entry_t       new_entry;
  logic             in_nan;
  mas_entry_t       cells [MAX_COUNT];
  logic             gb    [MAX_COUNT];

  // magnitude is the pattern without its sign bit
  assign new_entry.occ = 1'b1;
  assign new_entry.mag = s_tdata[MAG_W-1:0];
  assign new_entry.pos = POS_W'(count);
  assign in_nan        = (new_entry.mag > INF_MAG);

  mas_ctrl #(
    .MAX_COUNT(MAX_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_nan   (in_nan),
    .head_occ (cells[0].occ),
    .out_ready(m_tready),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .cmd      (cmd),
    .count    (count)
  );

  // cell 0 is the head (largest magnitude); empties collect at the tail
  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    mas_entry_t prev_e;
    logic       prev_gb;
    mas_entry_t next_e;

    if (i == 0) begin : g_head
      assign prev_e  = new_entry;
      assign prev_gb = 1'b0;
    end else begin : g_body
      assign prev_e  = cells[i-1];
      assign prev_gb = gb[i-1];
    end

    if (i == MAX_COUNT - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[i+1];
    end

    mas_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .cmd             (cmd),
      .new_entry       (new_entry),
      .prev_entry      (prev_e),
      .prev_goes_before(prev_gb),
      .next_entry      (next_e),
      .entry           (cells[i]),
      .goes_before     (gb[i])
    );
  end

  assign m_tdata = OUT_DATA_W'(cells[0].pos);
  assign m_tlast = !cells[1].occ;

  // row stays compact: an empty head means an empty second cell
  a_compact: assert property (@(posedge clk) disable iff (rst)
    !cells[0].occ |-> !cells[1].occ)
    else $error("cell row has a gap at the head");

  // row stays ordered by descending magnitude
  a_order: assert property (@(posedge clk) disable iff (rst)
    cells[1].occ |-> (cells[0].mag >= cells[1].mag))
    else $error("cell row out of order");

  // no input is taken while indices are offered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken during drain");

  // the last word switches the block to draining
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("no drain after last word");

endmodule

// File: rtl/mas_cell.sv
module mas_cell
  import mas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mas_cmd_t   cmd,
  input  mas_entry_t new_entry,
  input  mas_entry_t prev_entry,
  input  logic       prev_goes_before,
  input  mas_entry_t next_entry,
  output mas_entry_t entry,
  output logic       goes_before
);

  logic             occ;
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] pos;

  assign entry = {occ, mag, pos};

  // the new word belongs ahead of this cell's word (strict compare keeps arrival order)
  assign goes_before = !occ || (new_entry.mag > mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (cmd.drain) begin
      occ <= next_entry.occ;
    end else if (cmd.insert && goes_before) begin
      occ <= prev_goes_before ? prev_entry.occ : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      mag <= next_entry.mag;
      pos <= next_entry.pos;
    end else if (cmd.insert && goes_before) begin
      mag <= prev_goes_before ? prev_entry.mag : new_entry.mag;
      pos <= prev_goes_before ? prev_entry.pos : new_entry.pos;
    end
  end

endmodule

// File: rtl/mas_ctrl.sv
module mas_ctrl
  import mas_pkg::*;
#(
  parameter int MAX_COUNT = DEF_MAX_COUNT,
  localparam int CNT_W = $clog2(MAX_COUNT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  input  logic             in_nan,
  input  logic             head_occ,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output mas_cmd_t         cmd,
  output logic [CNT_W-1:0] count
);

  mas_state_t       state;
  mas_state_t       state_next;
  logic             in_acc;
  logic             full;
  logic [CNT_W-1:0] count_next;

  assign full   = (count >= CNT_W'(MAX_COUNT));
  assign in_acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_acc && in_last) state_next = ST_DRAIN;
      ST_DRAIN: if (!head_occ) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.insert = 1'b0;
    cmd.drain  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready   = 1'b1;
        cmd.insert = in_valid && !full && !in_nan;
      end
      ST_DRAIN: begin
        out_valid = head_occ;
        cmd.drain = head_occ && out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (in_acc) begin
      if (in_last) count_next = '0;
      else if (!full) count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// File: verif/magnitude_argsort_top_tb.sv
module magnitude_argsort_top_tb;
  import mas_pkg::*;

  localparam int SET_CAP        = DEF_MAX_COUNT;
  localparam int ITEM_TARGET    = 210;
  localparam int HOLD_OFF       = 400;   // long receiver stall, taken while a set is draining
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  // one value word waiting to be offered, with the idle cycles before it
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               is_last;
    int unsigned        gap;
  } value_word_t;

  // one expected rank word
  typedef struct packed {
    logic [POS_W-1:0] idx;
    logic             is_last;
  } rank_word_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  value_word_t pending[$];
  rank_word_t  rank_q[$];
  value_word_t next_word;
  rank_word_t  want;

  // predictor state: the set collected so far
  logic [MAG_W-1:0] set_mag[SET_CAP];
  bit               set_used[SET_CAP];
  int unsigned      set_count;

  int unsigned total_words;
  int unsigned words_in;
  int unsigned gap_count;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned sets_drained;
  int unsigned errors;
  logic [31:0] out_words;
  bit          held_off;

  magnitude_argsort_top #(
    .MAX_COUNT(SET_CAP)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(5, 30);
  endfunction

  // random double pattern, biased toward zeros, infinities, nans and ties
  function automatic logic [VALUE_W-1:0] pick_value(input logic [VALUE_W-1:0] prior);
    logic        sgn;
    logic [51:0] frac;
    sgn  = 1'($urandom_range(0, 1));
    frac = 52'({$urandom, $urandom});
    case ($urandom_range(0, 15))
      0:       return {sgn, 63'd0};
      1:       return {sgn, INF_MAG};
      2:       return {sgn, 11'h7ff, (frac == 52'd0) ? 52'd1 : frac};
      3:       return {sgn, 11'h000, frac};
      4, 5:    return {sgn, prior[MAG_W-1:0]};
      6:       return {sgn, 11'h7fe, frac};
      7, 8, 9: return {sgn, 11'h3ff, 49'd0, 3'($urandom_range(0, 7))};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_word(input logic [VALUE_W-1:0] value, input logic is_last,
                            input bit calm);
    value_word_t w;
    w.value   = value;
    w.is_last = is_last;
    w.gap     = calm ? 0 : pick_gap();
    pending.push_back(w);
    total_words++;
  endtask

  // add one accepted value to the set; on the last one, rank the set by
  // descending magnitude, lowest position first on a tie, nans left out
  task automatic take_value(input logic [VALUE_W-1:0] value, input logic is_last);
    logic [MAG_W-1:0] mag;
    bit               picked[SET_CAP];
    rank_word_t       r;
    int               n, best, k, j;
    mag = value[MAG_W-1:0];
    if (set_count < SET_CAP) begin
      if (mag <= INF_MAG) begin
        set_mag[set_count]  = mag;
        set_used[set_count] = 1'b1;
      end
      set_count++;
    end
    if (is_last) begin
      n = 0;
      for (k = 0; k < SET_CAP; k++) begin
        picked[k] = 1'b0;
        if (set_used[k]) n++;
      end
      for (j = 0; j < n; j++) begin
        best = -1;
        for (k = 0; k < SET_CAP; k++)
          if (set_used[k] && !picked[k] && (best < 0 || set_mag[k] > set_mag[best]))
            best = k;
        picked[best] = 1'b1;
        r.idx        = POS_W'(best);
        r.is_last    = (j == n - 1);
        rank_q.push_back(r);
      end
      for (k = 0; k < SET_CAP; k++) set_used[k] = 1'b0;
      set_count = 0;
    end
  endtask

  // sender: feeds the value words from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      gap_count <= 0;
      set_count = 0;
      for (int k = 0; k < SET_CAP; k++) set_used[k] = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_value(s_tdata, s_tlast);
        words_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && gap_count >= pending[0].gap) begin
          next_word = pending.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= next_word.value;
          s_tlast   <= next_word.is_last;
          gap_count <= 0;
        end else begin
          s_tvalid <= 1'b0;
          if (pending.size() != 0) gap_count <= gap_count + 1;
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      held_off   <= 1'b0;
    end else if (!held_off && m_tvalid && sets_drained == 4) begin
      m_tready   <= 1'b0;
      stall_left <= HOLD_OFF;
      held_off   <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (out_words[7:6] != 2'b01 && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // rank word checker
  always @(posedge clk) begin
    if (rst) begin
      out_words    <= '0;
      sets_drained <= 0;
    end else if (m_tvalid && m_tready) begin
      out_words <= out_words + 1;
      if (rank_q.size() == 0) begin
        $display("%0t: unexpected rank word, expected none, actual tdata %0h tlast %0b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = rank_q.pop_front();
        if (m_tdata !== {2'b00, want.idx}) begin
          $display("%0t: rank index mismatch, expected %0h, actual %0h",
                   $time, {2'b00, want.idx}, m_tdata);
          errors++;
        end
        if (m_tlast !== want.is_last) begin
          $display("%0t: last rank mismatch, expected %0b, actual %0b",
                   $time, want.is_last, m_tlast);
          errors++;
        end
        if (want.is_last) sets_drained <= sets_drained + 1;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("magnitude_argsort_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned      set_no, n, k;
    logic [VALUE_W-1:0] v;
    bit               calm;

    // single positive zero
    queue_word(64'h0000_0000_0000_0000, 1'b1, 1'b0);
    // mixed set: zeros, ties of opposite sign, infinities, nans, extremes
    queue_word(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    queue_word(64'h3ff0_0000_0000_0000, 1'b0, 1'b0);
    queue_word(64'hbff0_0000_0000_0000, 1'b0, 1'b0);
    queue_word(64'h7ff0_0000_0000_0000, 1'b0, 1'b0);
    queue_word(64'hfff0_0000_0000_0000, 1'b0, 1'b0);
    queue_word(64'h7ff8_0000_0000_0000, 1'b0, 1'b0);
    queue_word(64'h7fef_ffff_ffff_ffff, 1'b0, 1'b0);
    queue_word(64'h0000_0000_0000_0001, 1'b0, 1'b0);
    queue_word(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    queue_word(64'h7ff0_0000_0000_0001, 1'b0, 1'b0);
    queue_word(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
    queue_word(64'h0000_0000_0000_0000, 1'b1, 1'b0);
    // nans only, nothing comes out
    queue_word(64'hfff0_0000_0000_0001, 1'b0, 1'b0);
    queue_word(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0);
    // negative zero alone
    queue_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    // all equal magnitudes
    queue_word(64'h4000_0000_0000_0000, 1'b0, 1'b1);
    queue_word(64'hc000_0000_0000_0000, 1'b0, 1'b1);
    queue_word(64'h4000_0000_0000_0000, 1'b1, 1'b1);

    // random sets, mostly small; one exactly full, one overflowing so the
    // trailing words are dropped while the last flag still closes the set
    set_no = 0;
    while (total_words < ITEM_TARGET || set_no < 8) begin
      calm = (set_no % 4 == 2);
      if (set_no == 3) n = SET_CAP;
      else if (set_no == 7) n = SET_CAP + $urandom_range(1, 6);
      else n = $urandom_range(1, 14);
      v = {$urandom, $urandom};
      for (k = 0; k < n; k++) begin
        v = pick_value(v);
        queue_word(v, k == n - 1, calm);
      end
      set_no++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (words_in != total_words) @(posedge clk);
    while (rank_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("magnitude_argsort_top_tb: clean");
    end else begin
      $display("magnitude_argsort_top_tb: errors");
    end
    $finish;
  end

endmodule
